// ===== rtl/ttrc_pkg.sv =====
package ttrc_pkg;

    localparam int unsigned TERM_W = 16;
    localparam int unsigned POS_W  = 8;

    localparam logic [TERM_W-1:0] MODULUS     = 16'hFFFF;
    localparam logic [TERM_W-1:0] SEED_OLDER  = 16'd1;
    localparam logic [TERM_W-1:0] SEED_OFFSET = 16'd7;
    localparam logic [POS_W-1:0]  FIRST_NEXT  = 8'd1;

    // Sum of a 25-bit value's high and low parts, then one conditional subtract,
    // gives the value modulo 2^16 - 1.
    function automatic logic [TERM_W-1:0] fold_mod(input logic [24:0] x);
        logic [16:0] s;
        logic [16:0] r;
        begin
            s = {1'b0, x[15:0]} + {8'd0, x[24:16]};
            if (s >= {1'b0, MODULUS})
            begin
                r = s - {1'b0, MODULUS};
            end
            else
            begin
                r = s;
            end
            fold_mod = r[TERM_W-1:0];
        end
    endfunction

    // Coefficients of the position: 17*i and 31*i, both modulo 256.
    function automatic logic [POS_W-1:0] alpha_of(input logic [POS_W-1:0] pos);
        begin
            alpha_of = pos + {pos[3:0], 4'd0};
        end
    endfunction

    function automatic logic [POS_W-1:0] beta_of(input logic [POS_W-1:0] pos);
        begin
            beta_of = {pos[2:0], 5'd0} - pos;
        end
    endfunction

endpackage

// ===== rtl/three_term_recurrence_checksum.sv =====
// Channel | Direction | Handshake              | Fields
// input   | in        | in_valid / in_ready    | data_byte[7:0], first_byte, last_byte
// output  | out       | out_valid / out_ready  | checksum[15:0]
//
// One word per clock unless a last byte waits on a full result register. A word
// sits in the input register, then the recurrence (two short multiplies, a
// subtract and a fold modulo 65535) updates the terms and, on a last byte, loads
// the result register, which drives checksum valid.
// Reset clears the terms to one, the position to zero and both valid flags.
// Only a last byte waits on a full result register; other bytes keep flowing.
module three_term_recurrence_checksum
    import ttrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] checksum
);

    logic              in_vld_reg;
    logic [7:0]        in_byte_reg;
    logic              in_first_reg;
    logic              in_last_reg;

    logic [TERM_W-1:0] older_reg;
    logic [TERM_W-1:0] newer_reg;
    logic [POS_W-1:0]  pos_reg;

    logic              out_vld_reg;
    logic [TERM_W-1:0] sum_reg;

    logic              out_free;
    logic              proc_fire;

    logic [8:0]        factor_a;
    logic [24:0]       prod_a;
    logic [24:0]       prod_b;
    logic [24:0]       diff;
    logic [TERM_W-1:0] red;
    logic [TERM_W-1:0] term_calc;
    logic [TERM_W-1:0] older_next;
    logic [TERM_W-1:0] newer_next;
    logic [POS_W-1:0]  pos_next;

    assign out_free  = !out_vld_reg || out_ready;
    assign proc_fire = in_vld_reg && (!in_last_reg || out_free);
    assign in_ready  = !in_vld_reg || proc_fire;

    assign factor_a = {1'b0, in_byte_reg} + {1'b0, alpha_of(pos_reg)};
    assign prod_a   = {16'd0, factor_a} * {9'd0, newer_reg};
    assign prod_b   = {17'd0, beta_of(pos_reg)} * {9'd0, older_reg};

    always_comb
    begin
        if (prod_a >= prod_b)
        begin
            diff = prod_a - prod_b;
        end
        else
        begin
            diff = prod_b - prod_a;
        end
        red = fold_mod(diff);
        if (prod_a >= prod_b)
        begin
            term_calc = red;
        end
        // A wrapped 64-bit difference adds one modulo 65535, so the result
        // is 1 - red taken modulo 65535.
        else if (red == '0)
        begin
            term_calc = SEED_OLDER;
        end
        else if (red == SEED_OLDER)
        begin
            term_calc = '0;
        end
        else
        begin
            term_calc = ~red + SEED_OLDER;
        end

        if (in_first_reg)
        begin
            older_next = SEED_OLDER;
            newer_next = {8'd0, in_byte_reg} + SEED_OFFSET;
            pos_next   = FIRST_NEXT;
        end
        else
        begin
            older_next = newer_reg;
            newer_next = term_calc;
            pos_next   = pos_reg + FIRST_NEXT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            older_reg   <= SEED_OLDER;
            newer_reg   <= SEED_OLDER;
            pos_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_vld_reg <= in_valid;
            end
            if (proc_fire)
            begin
                older_reg <= older_next;
                newer_reg <= newer_next;
                pos_reg   <= pos_next;
            end
            if (proc_fire && in_last_reg)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg  <= data_byte;
            in_first_reg <= first_byte;
            in_last_reg  <= last_byte;
        end
        if (proc_fire && in_last_reg)
        begin
            sum_reg <= newer_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign checksum  = sum_reg;

    a_term_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        newer_reg != MODULUS && older_reg != MODULUS)
        else $error("recurrence term reached the modulus");

    a_out_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> sum_reg != MODULUS)
        else $error("checksum out of range");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_vld_reg && in_last_reg && out_vld_reg && !out_ready))
        else $error("input stalled without a blocked last word");

    a_seed_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && in_first_reg) |=> (pos_reg == FIRST_NEXT && older_reg == SEED_OLDER))
        else $error("first word did not seed the state");

    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && in_last_reg) |=> (out_vld_reg && sum_reg == newer_reg))
        else $error("result register does not match the newest term");

endmodule

// ===== verif/tb_three_term_recurrence_checksum.sv =====
module tb_three_term_recurrence_checksum;

    timeunit 1ns;
    timeprecision 1ps;

    import ttrc_pkg::TERM_W;
    import ttrc_pkg::POS_W;

    localparam int unsigned TERM_MOD   = 65535;
    localparam int          RAND_WORDS = 2000;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [7:0]        data_byte;
    logic              first_byte;
    logic              last_byte;
    logic              out_valid;
    logic              out_ready;
    logic [TERM_W-1:0] checksum;

    typedef struct packed {
        logic [7:0]        data;
        logic              first;
        logic              last;
        logic              typed;
        logic [TERM_W-1:0] sum;
    } stim_row_t;

    // Rows marked typed carry a checksum known by hand; the rest use the predictor.
    localparam int N_DIRECTED = 21;
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{8'h5A, 1'b0, 1'b1, 1'b1, 16'h005A},  // no first mark since reset
        '{8'hFF, 1'b1, 1'b1, 1'b1, 16'h0106},  // one-byte message, largest byte
        '{8'h00, 1'b1, 1'b1, 1'b1, 16'h0007},  // one-byte message, zero byte
        '{8'h00, 1'b1, 1'b0, 1'b0, 16'h0000},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{8'h00, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{8'h80, 1'b0, 1'b1, 1'b0, 16'h0000},
        '{8'h11, 1'b1, 1'b0, 1'b0, 16'h0000},
        '{8'h22, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{8'h33, 1'b1, 1'b0, 1'b0, 16'h0000},  // restart in the middle
        '{8'h44, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{8'h55, 1'b0, 1'b1, 1'b0, 16'h0000},
        '{8'h01, 1'b0, 1'b1, 1'b0, 16'h0000},  // carries on after a last byte
        '{8'hFF, 1'b1, 1'b0, 1'b0, 16'h0000},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{8'hFF, 1'b0, 1'b1, 1'b0, 16'h0000},
        '{8'h7F, 1'b1, 1'b1, 1'b1, 16'h0086},
        '{8'h00, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{8'hA5, 1'b0, 1'b1, 1'b0, 16'h0000}
    };

    logic [TERM_W-1:0] sum_older;
    logic [TERM_W-1:0] sum_newer;
    logic [POS_W-1:0]  sum_pos;
    logic [TERM_W-1:0] pending_sums [$];

    int errors     = 0;
    int send_calm  = 0;
    int recv_calm  = 0;
    int words_sent = 0;

    three_term_recurrence_checksum u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .checksum   (checksum)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Wait in cycles before a word or a checksum, with occasional runs that do not wait.
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm = calm - 1;
            return 0;
        end
        if ($urandom_range(0, 40) == 0)
        begin
            calm = $urandom_range(20, 60);
        end
        return $urandom_range(0, 8);
    endfunction

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 7) == 0)
        begin
            return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Next recurrence term; a negative difference wraps as in 64-bit arithmetic.
    function automatic logic [TERM_W-1:0] recur_term(input logic [7:0] b);
        logic [7:0]      alpha;
        logic [7:0]      beta;
        longint unsigned lhs;
        longint unsigned rhs;
        longint unsigned d;
        alpha = 8'(sum_pos * 17);
        beta  = 8'(sum_pos * 31);
        lhs = (longint'(b) + longint'(alpha)) * longint'(sum_newer);
        rhs = longint'(beta) * longint'(sum_older);
        if (lhs >= rhs)
        begin
            return TERM_W'((lhs - rhs) % TERM_MOD);
        end
        d = (rhs - lhs) % TERM_MOD;
        return TERM_W'((TERM_MOD + 1 - d) % TERM_MOD);
    endfunction

    task automatic advance_checksum(input logic [7:0] b, input logic f, input logic l,
                                    output logic emits, output logic [TERM_W-1:0] sum);
        logic [TERM_W-1:0] t;
        if (f)
        begin
            sum_older = TERM_W'(1);
            sum_newer = TERM_W'(b) + TERM_W'(7);
            sum_pos   = POS_W'(1);
        end
        else
        begin
            t         = recur_term(b);
            sum_older = sum_newer;
            sum_newer = t;
            sum_pos   = sum_pos + POS_W'(1);
        end
        emits = l;
        sum   = sum_newer;
    endtask

    task automatic report_mismatch(input string what, input logic [TERM_W-1:0] got,
                                   input logic [TERM_W-1:0] want);
        $display("mismatch at %0t: %s, got %h, want %h", $realtime, what, got, want);
        errors++;
    endtask

    // Entered at a rising edge; returns at the edge where the word is accepted.
    task automatic send_word(input logic [7:0] d, input logic f, input logic l,
                             input logic typed, input logic [TERM_W-1:0] typed_sum);
        int                gap;
        logic              emits;
        logic [TERM_W-1:0] sum;
        gap = draw_wait(send_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= d;
        first_byte <= f;
        last_byte  <= l;
        do @(posedge clk); while (!in_ready);
        advance_checksum(d, f, l, emits, sum);
        if (emits)
        begin
            pending_sums.push_back(typed ? typed_sum : sum);
        end
        words_sent++;
    endtask

    initial
    begin
        int                gap;
        logic [TERM_W-1:0] want;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = draw_wait(recv_calm);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            if (pending_sums.size() == 0)
            begin
                report_mismatch("checksum with none expected", checksum, '0);
            end
            else
            begin
                want = pending_sums.pop_front();
                if (checksum !== want)
                begin
                    report_mismatch("checksum", checksum, want);
                end
            end
        end
    end

    initial
    begin
        int   mode;
        int   len;
        int   restart_at;
        logic drop_first;
        logic f;
        logic l;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        data_byte  = 8'h00;
        first_byte = 1'b0;
        last_byte  = 1'b0;
        out_ready  = 1'b0;
        sum_older  = TERM_W'(1);
        sum_newer  = TERM_W'(1);
        sum_pos    = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            send_word(DIRECTED[i].data, DIRECTED[i].first, DIRECTED[i].last,
                      DIRECTED[i].typed, DIRECTED[i].sum);
        end

        words_sent = 0;
        while (words_sent < RAND_WORDS)
        begin
            mode = $urandom_range(0, 99);
            if (mode < 93)
            begin
                // Mostly well-formed messages; some long ones wrap the position.
                if ($urandom_range(0, 29) == 0)
                begin
                    len = $urandom_range(257, 300);
                end
                else
                begin
                    len = $urandom_range(1, 24);
                end
                drop_first = (mode >= 85) && ($urandom_range(0, 1) == 1);
                restart_at = (mode >= 85 && !drop_first) ? int'($urandom_range(1, len)) : -1;
                for (int i = 0; i < len; i++)
                begin
                    f = ((i == 0) && !drop_first) || (i == restart_at);
                    l = (i == len - 1);
                    send_word(pick_byte(), f, l, 1'b0, '0);
                end
            end
            else
            begin
                len = $urandom_range(1, 10);
                for (int i = 0; i < len; i++)
                begin
                    send_word(pick_byte(), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 1'b0, '0);
                end
            end
        end
        in_valid <= 1'b0;

        wait (pending_sums.size() == 0);
        repeat (10) @(posedge clk);
        if (errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
